// ===== rtl/crci_pkg.sv =====
// shared widths, fixed-point constants and scaling helper for the cubic interpolator
package crci_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 17;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int FRAC_BITS = 16;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // arithmetic shift of a full product by the fraction bits, keep the low word
    function automatic word_t fx_scale(input prod_t p);
        prod_t sh;
        sh = p >>> FRAC_BITS;
        return sh[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/crci_fmul.sv =====
// registered signed word by word multiplier stage
module crci_fmul
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    a,
    input  logic signed [31:0]    b,
    output crci_pkg::prod_t       prod
);

    crci_pkg::prod_t prod_reg;
    crci_pkg::prod_t prod_next;

    assign prod_next = crci_pkg::prod_t'(a) * crci_pkg::prod_t'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/catmull_rom_cubic_interp.sv =====
// catmull-rom cubic interpolator, signed q16.16, five-stage pipeline
//
// Takes four neighboring signed Q16.16 samples and a Q1.16 fraction and returns
// 0.5*(2y1 + (y2-y0)x + (2y0-5y1+4y2-y3)x^2 + (-y0+3y1-3y2+y3)x^3). Every
// fixed-point product is the full signed 64-bit product shifted right
// arithmetically by the fraction bits and cut to 32 bits; sums wrap modulo 2^32
// and the final halving rounds toward zero. A fraction above one is used as
// given, so the curve is extrapolated. One word is taken per clock while
// in_stall is low, and each result passes through the five register stages
// in order (coefficients and x^2, x^3 and the linear term, the square and
// cube terms, the final sum, the halving). A stall on the output holds the
// pipeline, but empty stages still fill, so in_stall rises only when all
// five stages hold a word.
module catmull_rom_cubic_interp
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_before,
    input  logic [31:0] sample_start,
    input  logic [31:0] sample_end,
    input  logic [31:0] sample_after,
    input  logic [16:0] fraction,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] interpolated
);

    // per-stage valid bits and advance enables (stage 1 is index 0)
    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] adv;

    // stage 1: coefficients, fraction and x*x
    crci_pkg::word_t c0_1_reg, c1_1_reg, c2_1_reg, c3_1_reg;
    crci_pkg::frac_t x_1_reg;
    crci_pkg::word_t c0_1_next, c1_1_next, c2_1_next, c3_1_next;
    crci_pkg::prod_t pxx;
    crci_pkg::word_t xin_w;

    // stage 2: x^2, x^3 product and linear product
    crci_pkg::word_t c0_2_reg, c2_2_reg, c3_2_reg, x2_2_reg;
    crci_pkg::word_t x2_1;
    crci_pkg::word_t x_1_w;
    crci_pkg::prod_t px3;
    crci_pkg::prod_t pc1;

    // stage 3: square and cube products
    crci_pkg::word_t c0_3_reg, t1_3_reg;
    crci_pkg::word_t x3_2;
    crci_pkg::prod_t pc2;
    crci_pkg::prod_t pc3;

    // stage 4: full sum, stage 5: halved result
    crci_pkg::word_t sum_4_reg, sum_4_next;
    crci_pkg::word_t res_5_reg, res_5_next;
    crci_pkg::word_t mag;
    crci_pkg::word_t mag_half;
    logic            neg;

    // ---------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or its successor moves
    // ---------------------------------------------------------------------
    always_comb
    begin
        adv[4] = !vld_reg[4] || !out_stall;
        adv[3] = !vld_reg[3] || adv[4];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
        vld_next[0] = adv[0] ? in_valid   : vld_reg[0];
        vld_next[1] = adv[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = adv[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = adv[3] ? vld_reg[2] : vld_reg[3];
        vld_next[4] = adv[4] ? vld_reg[3] : vld_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[4];

    // ---------------------------------------------------------------------
    // stage 1: coefficients by shifts and adds, x*x
    // ---------------------------------------------------------------------
    always_comb
    begin
        c0_1_next = sample_start << 1;
        c1_1_next = sample_end - sample_before;
        c2_1_next = (sample_before << 1) - ((sample_start << 2) + sample_start)
                  + (sample_end << 2) - sample_after;
        c3_1_next = (32'd0 - sample_before) + ((sample_start << 1) + sample_start)
                  - ((sample_end << 1) + sample_end) + sample_after;
    end

    assign xin_w = crci_pkg::word_t'(fraction);

    crci_fmul u_mul_xx
    (
        .clk  (clk),
        .en   (adv[0]),
        .a    (xin_w),
        .b    (xin_w),
        .prod (pxx)
    );

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            c0_1_reg <= c0_1_next;
            c1_1_reg <= c1_1_next;
            c2_1_reg <= c2_1_next;
            c3_1_reg <= c3_1_next;
            x_1_reg  <= fraction;
        end
    end

    // ---------------------------------------------------------------------
    // stage 2: x^2 scaled, x^3 = x^2*x, linear term c1*x
    // ---------------------------------------------------------------------
    assign x2_1  = crci_pkg::fx_scale(pxx);
    assign x_1_w = crci_pkg::word_t'(x_1_reg);

    crci_fmul u_mul_x3
    (
        .clk  (clk),
        .en   (adv[1]),
        .a    (x2_1),
        .b    (x_1_w),
        .prod (px3)
    );

    crci_fmul u_mul_c1
    (
        .clk  (clk),
        .en   (adv[1]),
        .a    (c1_1_reg),
        .b    (x_1_w),
        .prod (pc1)
    );

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            c0_2_reg <= c0_1_reg;
            c2_2_reg <= c2_1_reg;
            c3_2_reg <= c3_1_reg;
            x2_2_reg <= x2_1;
        end
    end

    // ---------------------------------------------------------------------
    // stage 3: square term c2*x^2, cube term c3*x^3
    // ---------------------------------------------------------------------
    assign x3_2 = crci_pkg::fx_scale(px3);

    crci_fmul u_mul_c2
    (
        .clk  (clk),
        .en   (adv[2]),
        .a    (c2_2_reg),
        .b    (x2_2_reg),
        .prod (pc2)
    );

    crci_fmul u_mul_c3
    (
        .clk  (clk),
        .en   (adv[2]),
        .a    (c3_2_reg),
        .b    (x3_2),
        .prod (pc3)
    );

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c0_3_reg <= c0_2_reg;
            t1_3_reg <= crci_pkg::fx_scale(pc1);
        end
    end

    // ---------------------------------------------------------------------
    // stage 4: wrapping sum of the four terms
    // ---------------------------------------------------------------------
    assign sum_4_next = c0_3_reg + t1_3_reg + crci_pkg::fx_scale(pc2)
                      + crci_pkg::fx_scale(pc3);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sum_4_reg <= sum_4_next;
        end
    end

    // ---------------------------------------------------------------------
    // stage 5: halve the magnitude, rounding toward zero
    // ---------------------------------------------------------------------
    always_comb
    begin
        neg        = sum_4_reg[31];
        mag        = neg ? (32'd0 - sum_4_reg) : sum_4_reg;
        mag_half   = mag >> 1;
        res_5_next = neg ? (32'd0 - mag_half) : mag_half;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            res_5_reg <= res_5_next;
        end
    end

    assign interpolated = res_5_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------

    // input backs off only when every stage holds a word
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (vld_reg == 5'b11111))
        else $error("input stalled with an empty pipeline stage");

    // words in flight change only through the two handshakes
    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && !in_stall) && !(out_valid && !out_stall))
        |=> ($countones(vld_reg) == $past($countones(vld_reg))))
        else $error("word lost or invented inside the pipeline");

    // halving keeps the result within plus or minus 2^30
    a_halved_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (interpolated[31] == interpolated[30]))
        else $error("result outside the halved range");

endmodule
